@@ rtl/core/mre_pkg.sv @@
// shared types and constants of the median residual encoder
package mre_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CLS_RAW = 2'd0,
        CLS_ROW = 2'd1,
        CLS_COL = 2'd2,
        CLS_MED = 2'd3
    } pixel_class_t;

    // one classified pixel with its neighborhood
    typedef struct packed {
        logic [7:0]   pixel;
        logic [7:0]   left;
        logic [7:0]   up;
        logic [7:0]   upper_left;
        pixel_class_t pclass;
        logic         eof;
    } mre_item_t;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  empty;
    } fifo_status_t;

endpackage

@@ rtl/core/mre_ram.sv @@
// generic single-write, single-read ram with registered read data
module mre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mre_front.sv @@
// front part: accepts pixels, tracks position, reads the line buffer, classifies
module mre_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [12:0]           image_width,
    input  logic [15:0]           image_height,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  mre_pkg::fifo_status_t fifo_status,
    output logic                  push,
    output mre_pkg::mre_item_t    push_item
);

    logic [mre_pkg::COL_W-1:0] col_reg, col_next;
    logic [15:0]               row_reg, row_next;
    logic [7:0]                left_reg, left_next;
    logic [7:0]                ul_reg, ul_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic [7:0]                s1_pix_reg;
    logic [7:0]                s1_left_reg;
    mre_pkg::pixel_class_t     s1_class_reg;
    logic                      s1_eof_reg;

    logic                      accept;
    logic [mre_pkg::COL_W-1:0] width_m1;
    logic [15:0]               height_m1;
    logic                      row_end;
    logic                      frame_end;
    mre_pkg::pixel_class_t     pclass;
    logic [7:0]                up_pixel;

    // room for the item in flight plus the new one
    assign s_tready = (32'(fifo_status.count) + 32'(s1_valid_reg)) < 32'(mre_pkg::FIFO_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (image_width == 13'd0)
        begin
            width_m1 = '0;
        end
        else if (32'(image_width) > 32'(mre_pkg::MAX_WIDTH))
        begin
            width_m1 = mre_pkg::COL_W'(mre_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            width_m1 = mre_pkg::COL_W'(image_width - 13'd1);
        end
        height_m1 = (image_height == 16'd0) ? 16'd0 : image_height - 16'd1;
    end

    assign row_end   = (col_reg >= width_m1);
    assign frame_end = row_end && (row_reg >= height_m1);

    always_comb
    begin
        if (row_reg == 16'd0 && col_reg == '0)
        begin
            pclass = mre_pkg::CLS_RAW;
        end
        else if (row_reg == 16'd0)
        begin
            pclass = mre_pkg::CLS_ROW;
        end
        else if (col_reg == '0)
        begin
            pclass = mre_pkg::CLS_COL;
        end
        else
        begin
            pclass = mre_pkg::CLS_MED;
        end
    end

    mre_ram #(
        .WIDTH (8),
        .DEPTH (mre_pkg::MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (s_tdata),
        .raddr (col_reg),
        .rdata (up_pixel)
    );

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        left_next     = left_reg;
        ul_next       = ul_reg;
        s1_valid_next = accept;
        if (accept)
        begin
            left_next = s_tdata;
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + 16'd1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        if (s1_valid_reg)
        begin
            ul_next = up_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            ul_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            left_reg     <= left_next;
            ul_reg       <= ul_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= s_tdata;
            s1_left_reg  <= left_reg;
            s1_class_reg <= pclass;
            s1_eof_reg   <= frame_end;
        end
    end

    assign push                 = s1_valid_reg;
    assign push_item.pixel      = s1_pix_reg;
    assign push_item.left       = s1_left_reg;
    assign push_item.up         = up_pixel;
    assign push_item.upper_left = ul_reg;
    assign push_item.pclass     = s1_class_reg;
    assign push_item.eof        = s1_eof_reg;

endmodule

@@ rtl/core/mre_fifo.sv @@
// short queue of classified pixels between front and back parts
module mre_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mre_pkg::mre_item_t    push_item,
    input  logic                  pop,
    output mre_pkg::mre_item_t    head_item,
    output mre_pkg::fifo_status_t status
);

    mre_pkg::mre_item_t             entry_reg [mre_pkg::FIFO_DEPTH];
    logic [mre_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mre_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mre_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == mre_pkg::FIFO_CNT_W'(mre_pkg::FIFO_DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

endmodule

@@ rtl/core/mre_back.sv @@
// back part: median prediction, residual folding and the output register
module mre_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mre_pkg::mre_item_t    head_item,
    input  mre_pkg::fifo_status_t fifo_status,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic                  out_valid_reg, out_valid_next;
    logic [8:0]            sym_reg;
    mre_pkg::pixel_class_t class_reg;
    logic                  eof_reg;

    logic [7:0] hi;
    logic [7:0] lo;
    logic [9:0] grad;
    logic [7:0] med;
    logic [7:0] pred;
    logic [8:0] sym;

    assign pop = !fifo_status.empty && (!out_valid_reg || m_tready);

    always_comb
    begin
        hi   = (head_item.left > head_item.up) ? head_item.left : head_item.up;
        lo   = (head_item.left > head_item.up) ? head_item.up : head_item.left;
        grad = 10'(head_item.left) + 10'(head_item.up) - 10'(head_item.upper_left);
        if (head_item.upper_left >= hi)
        begin
            med = lo;
        end
        else if (head_item.upper_left <= lo)
        begin
            med = hi;
        end
        else
        begin
            med = grad[7:0];
        end

        case (head_item.pclass)
            mre_pkg::CLS_ROW: pred = head_item.left;
            mre_pkg::CLS_COL: pred = head_item.up;
            default:          pred = med;
        endcase

        // fold: non-negative error to even codes, negative to odd
        if (head_item.pclass == mre_pkg::CLS_RAW)
        begin
            sym = {1'b0, head_item.pixel};
        end
        else if (pred <= head_item.pixel)
        begin
            sym = {head_item.pixel - pred, 1'b0};
        end
        else
        begin
            sym = {pred - head_item.pixel, 1'b0} - 9'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sym_reg   <= sym;
            class_reg <= head_item.pclass;
            eof_reg   <= head_item.eof;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, sym_reg};
    assign m_tuser  = class_reg;
    assign m_tlast  = eof_reg;

endmodule

@@ rtl/core/med_residual_encoder.sv @@
// top level of the median residual encoder with its register port
// a pixel's symbol passes the line buffer read, the queue and the output register
// throughput: one pixel per cycle while the queue has room, set by the
//   single-port-per-side line buffer ram
// reset: position, neighbor registers, queue and output clear; width and height
//   return to 1; the line buffer holds no defined data until rows are written
module med_residual_encoder (
    input  logic        clk,
    input  logic        rst_n,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    // symbol output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [8:0] residual_symbol, [15:9] zero
    output logic [1:0]  m_tuser,   // [1:0] pixel_class
    output logic        m_tlast,   // end_of_frame
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic        reg_write;
    logic        reg_index;

    logic                  push;
    logic                  pop;
    mre_pkg::mre_item_t    push_item;
    mre_pkg::mre_item_t    head_item;
    mre_pkg::fifo_status_t fifo_status;

    // register port: always ready, index from the word address
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign reg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (reg_write)
        begin
            unique case (reg_index)
                mre_pkg::REG_WIDTH:  width_next  = pwdata[12:0];
                mre_pkg::REG_HEIGHT: height_next = pwdata[15:0];
                default:             width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 16'd1;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            mre_pkg::REG_WIDTH:  prdata = {19'd0, width_reg};
            mre_pkg::REG_HEIGHT: prdata = {16'd0, height_reg};
            default:             prdata = '0;
        endcase
    end

    // front: position tracking, line buffer and classification
    mre_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .fifo_status  (fifo_status),
        .push         (push),
        .push_item    (push_item)
    );

    // decoupling queue
    mre_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (fifo_status)
    );

    // back: prediction, folding and output register
    mre_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_item   (head_item),
        .fifo_status (fifo_status),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // a raw first pixel carries an 8-bit sample only
    a_raw_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == mre_pkg::CLS_RAW) |-> m_tdata[15:8] == 8'd0)
        else $error("raw symbol wider than a pixel");

    // folded residuals stop at 510
    a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:9] == 7'd0 && m_tdata[8:0] != 9'h1FF))
        else $error("symbol out of range");

endmodule

@@ test/tb_top.sv @@
// testbench of the median residual encoder: directed frames, a wide row and random frames
module tb_top;

    // one expected output symbol, in the form the master side presents it
    typedef struct packed {
        logic [15:0]           data;
        mre_pkg::pixel_class_t pclass;
        logic                  last;
    } coded_symbol_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;       // [7:0] pixel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [8:0] residual_symbol, [15:9] zero
    logic [1:0]  m_tuser;            // [1:0] pixel_class
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the block: registers, position, neighbors and line buffer
    logic [12:0] width_reg = 13'd1;
    logic [15:0] height_reg = 16'd1;
    int          col_pos = 0;
    int          row_pos = 0;
    int          left_pix = 0;
    int          upper_left_pix = 0;
    bit [7:0]    line_buf [mre_pkg::MAX_WIDTH];

    coded_symbol_t expected_symbols [$];
    int            pixels_sent = 0;
    int            mismatch_count = 0;
    bit            steady_flow = 1'b0;   // both sides run without idle cycles
    int            hold_cycles = 0;      // long receiver hold-off, taken once

    med_residual_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // work out the symbol of one pixel and advance the shadow state
    function automatic coded_symbol_t encode_pixel(input logic [7:0] pixel);
        int            eff_width;
        int            eff_height;
        int            pix;
        int            up;
        int            pred;
        int            hi;
        int            lo;
        int            sym;
        bit            row_end;
        bit            frame_end;
        coded_symbol_t res;
        pix = pixel;
        // zero sizes act as one, widths past the line buffer saturate
        eff_width = (width_reg == 0) ? 1 :
                    ((width_reg > mre_pkg::MAX_WIDTH) ? mre_pkg::MAX_WIDTH : width_reg);
        eff_height = (height_reg == 0) ? 1 : height_reg;
        up = line_buf[col_pos];
        pred = 0;
        if (row_pos == 0 && col_pos == 0)
        begin
            res.pclass = mre_pkg::CLS_RAW;
        end
        else if (row_pos == 0)
        begin
            res.pclass = mre_pkg::CLS_ROW;
            pred = left_pix;
        end
        else if (col_pos == 0)
        begin
            res.pclass = mre_pkg::CLS_COL;
            pred = up;
        end
        else
        begin
            // median edge detector over left, upper-left and up
            res.pclass = mre_pkg::CLS_MED;
            hi = (left_pix > up) ? left_pix : up;
            lo = (left_pix > up) ? up : left_pix;
            if (upper_left_pix >= hi)
                pred = lo;
            else if (upper_left_pix <= lo)
                pred = hi;
            else
                pred = left_pix + up - upper_left_pix;
        end
        if (res.pclass == mre_pkg::CLS_RAW)
            sym = pix;
        else if (pred <= pix)
            sym = 2 * (pix - pred);
        else
            sym = 2 * (pred - pix) - 1;

        upper_left_pix = up;
        line_buf[col_pos] = pixel;
        left_pix = pix;

        // a width lowered in mid row ends the row at once
        row_end = (col_pos >= eff_width - 1);
        frame_end = row_end && (row_pos >= eff_height - 1);
        if (frame_end)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else if (row_end)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 16'hFFFF;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        res.data = {7'd0, sym[8:0]};
        res.last = frame_end;
        return res;
    endfunction

    // pixel content: noise, smooth ramps near the last pixel, or rail values
    function automatic logic [7:0] pick_pixel();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'($urandom_range(0, 255));
        if (r < 8)
        begin
            v = left_pix + $urandom_range(0, 12) - 6;
            v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
            return 8'(v);
        end
        return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endfunction

    // offer one pixel request after a random gap and log its expected symbol
    task automatic send_pixel(input logic [7:0] pixel);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pixel;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_symbols.push_back(encode_pixel(pixel));
        pixels_sent++;
    endtask

    // stop offering and let every outstanding symbol come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_symbols.size() != 0)
            @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle until pready, then back to idle
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == mre_pkg::REG_WIDTH)
            width_reg = value[12:0];
        else
            height_reg = value[15:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame_size(input int w, input int h);
        wait_drained();
        write_register(mre_pkg::REG_WIDTH, w);
        write_register(mre_pkg::REG_HEIGHT, h);
    endtask

    // reset sizes: every pixel is a one-pixel frame sent raw
    task automatic test_reset_frame();
        send_pixel(8'hA5);
        send_pixel(8'h5A);
    endtask

    // zero sizes, the tallest frame and a height cut in mid frame
    task automatic test_degenerate_sizes();
        set_frame_size(0, 0);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        // one column: rail to rail swings give the largest symbols
        set_frame_size(1, 65535);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h80);
        // row count is already past the new height, so the next pixel ends the frame
        wait_drained();
        write_register(mre_pkg::REG_HEIGHT, 3);
        send_pixel(8'h4D);
    endtask

    // 3x3 frame that walks the median through all three branches
    task automatic test_median_branches();
        logic [7:0] frame [9] = '{8'd10, 8'd200, 8'd30,
                                  8'd100, 8'd0, 8'd255,
                                  8'd150, 8'd60, 8'd7};
        set_frame_size(3, 3);
        foreach (frame[i])
            send_pixel(frame[i]);
    endtask

    // width lowered in mid row ends that row on the next pixel
    task automatic test_narrowed_row();
        set_frame_size(8, 2);
        repeat (5) send_pixel(pick_pixel());
        wait_drained();
        write_register(mre_pkg::REG_WIDTH, 3);
        repeat (4) send_pixel(pick_pixel());
    endtask

    // wide row fills the first 32 line buffer entries, then an oversize width
    // is written in row 1 and must not end the row early
    task automatic test_wide_row();
        set_frame_size(32, 2);
        repeat (32) send_pixel(pick_pixel());
        wait_drained();
        write_register(mre_pkg::REG_WIDTH, 8191);
        repeat (3) send_pixel(pick_pixel());
        wait_drained();
        write_register(mre_pkg::REG_WIDTH, 2);
        send_pixel(pick_pixel());
    endtask

    // receiver holds off long enough for the input side to back up
    task automatic test_backpressure();
        set_frame_size(16, 4);
        steady_flow = 1'b1;
        hold_cycles = 80;
        repeat (64) send_pixel(pick_pixel());
        steady_flow = 1'b0;
    endtask

    // random frame sizes with occasional register writes in mid frame;
    // widths raised in mid frame stay within the 32 entries written above
    task automatic test_random_frames();
        int stop_at;
        int r;
        int w;
        int h;
        int split;
        int n;
        stop_at = pixels_sent + 1320;
        while (pixels_sent < stop_at)
        begin
            steady_flow = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                w = 0;
                h = $urandom_range(0, 6);
            end
            else if (r < 3)
            begin
                w = $urandom_range(17, 80);
                h = $urandom_range(1, 2);
            end
            else
            begin
                w = $urandom_range(1, 16);
                h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            end
            set_frame_size(w, h);
            split = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : -1;
            n = 0;
            do
            begin
                send_pixel(pick_pixel());
                n++;
                if (n == split && !(col_pos == 0 && row_pos == 0))
                begin
                    wait_drained();
                    if ($urandom_range(0, 1) != 0)
                        write_register(mre_pkg::REG_WIDTH, $urandom_range(0, 24));
                    else
                        write_register(mre_pkg::REG_HEIGHT, $urandom_range(0, 8));
                end
            end
            while (!(col_pos == 0 && row_pos == 0));
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_frame();
        test_degenerate_sizes();
        test_median_branches();
        test_narrowed_row();
        test_wide_row();
        test_backpressure();
        test_random_frames();
        wait_drained();
        // keep the clock running to catch any stray symbol
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // output side: random stall per symbol, plus the one long hold-off when asked
    initial
    begin : symbol_sink
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 9);
            if (hold_cycles > 0)
            begin
                stall = stall + hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // compare each accepted symbol against the oldest pending one
    always @(posedge clk)
    begin : symbol_check
        coded_symbol_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_symbols.size() == 0)
            begin
                $display("%0t: unexpected symbol, expected none, got data %0d class %0d last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = expected_symbols.pop_front();
                if (m_tdata !== want.data)
                begin
                    $display("%0t: symbol mismatch, expected %0d, got %0d",
                             $time, want.data, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.pclass)
                begin
                    $display("%0t: class mismatch, expected %0d, got %0d",
                             $time, want.pclass, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: end of frame mismatch, expected %0b, got %0b",
                             $time, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
